// File: src/tepq_pkg.sv
// ----------------------------------------------------------------------------
// Timed edge priority queue: shared package
// Field widths, beat payload structs, request and kind codes, and the
// sequencer state type used by the queue controller.
// ----------------------------------------------------------------------------
package tepq_pkg;

  // Field widths fixed by the beat formats.
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 2;
  localparam int CAM_W   = 8;
  localparam int MASK_W  = 8;
  localparam int REQ_W   = 2;
  localparam int DELAY_W = 31;
  localparam int FILL_W  = 5;

  // Free slots a plan needs, lit and unlit.
  localparam int PLAN_LIT_EDGES   = 4;
  localparam int PLAN_UNLIT_EDGES = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLAN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;

  // Edge kinds, in their tie-break order.
  localparam logic [KIND_W-1:0] KIND_ASSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ILLUM_ON  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ILLUM_OFF = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE   = 2'd3;

  // One stored edge.
  typedef struct packed {
    logic [TIME_W-1:0] due_time;
    logic [KIND_W-1:0] kind;
    logic [CAM_W-1:0]  camera;
    logic [MASK_W-1:0] mask;
  } edge_t;

  // Input beat.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] edge_time;
    logic [KIND_W-1:0] edge_kind;
    logic [CAM_W-1:0]  camera_num;
    logic [MASK_W-1:0] illum_mask;
    logic [TIME_W-1:0] assert_time;
    logic [TIME_W-1:0] illum_on_time;
    logic [TIME_W-1:0] illum_off_time;
    logic [TIME_W-1:0] release_time;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic               accepted;
    logic [TIME_W-1:0]  out_time;
    logic [KIND_W-1:0]  out_kind;
    logic [CAM_W-1:0]   out_camera;
    logic [MASK_W-1:0]  out_mask;
    logic               has_next;
    logic [DELAY_W-1:0] head_wait;
    logic [FILL_W-1:0]  fill_count;
  } out_item_t;

  // Controller sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_START,
    ST_INS_CMP,
    ST_INS_WR,
    ST_POP_RD,
    ST_POP_CHK,
    ST_POP_SH,
    ST_FIN_RD,
    ST_FIN_WAIT
  } state_t;

endpackage

// File: src/tepq_if.sv
// ----------------------------------------------------------------------------
// Timed edge priority queue: channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface tepq_in_if
  import tepq_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tepq_out_if
  import tepq_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/tepq_store.sv
// ----------------------------------------------------------------------------
// Timed edge priority queue: edge store
// Synchronous single-write, single-read memory of edges with a registered
// read port (old data on a same-address write).
// ----------------------------------------------------------------------------
module tepq_store
  import tepq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  edge_t                       wr_data,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output edge_t                       rd_data
);

  edge_t mem [CAPACITY];
  edge_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/tepq_ctrl.sv
// ----------------------------------------------------------------------------
// Timed edge priority queue: controller
// Sequences sorted inserts and head pops over the edge store one entry per
// cycle, tracks the fill count and builds the result beat.
// ----------------------------------------------------------------------------
module tepq_ctrl
  import tepq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tepq_in_if.sink                     in_ch,
  tepq_out_if.source                  out_ch,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output edge_t                       wr_data,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  edge_t                       rd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C      = CW'(CAPACITY);
  localparam logic [CW-1:0] NEED_LIT   = CW'(PLAN_LIT_EDGES);
  localparam logic [CW-1:0] NEED_UNLIT = CW'(PLAN_UNLIT_EDGES);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  in_item_t          req_r, req_nxt;
  edge_t             cur_r, cur_nxt;
  logic [TIME_W-1:0] cur_dist_r, cur_dist_nxt;
  logic              last_r, last_nxt;
  logic              lit_r, lit_nxt;
  edge_t             pop_r, pop_nxt;
  logic              acc_r, acc_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              edge_done;
  logic              runs_first;
  logic              head_due;
  logic [TIME_W-1:0] mem_dist;
  logic [CW-1:0]     free_slots;
  logic [CW-1:0]     plan_need;
  logic [KIND_W-1:0] next_kind;
  logic [TIME_W-1:0] next_time;
  logic [CW:0]       sh_next;
  logic [DELAY_W-1:0] delay;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    cur_dist_r <= cur_dist_nxt;
    last_r     <= last_nxt;
    lit_r      <= lit_nxt;
    pop_r      <= pop_nxt;
    acc_r      <= acc_nxt;
    out_r      <= out_nxt;
  end

  // Distance of the entry being read, and the ordering tests against it.
  always_comb begin
    mem_dist   = rd_data.due_time - req_r.now_us;
    runs_first = ($signed(cur_dist_r) < $signed(mem_dist)) ||
                 ((cur_dist_r == mem_dist) && (cur_r.kind < rd_data.kind));
    head_due   = (mem_dist == '0) || mem_dist[TIME_W-1];
    delay      = ((count_r != '0) && (mem_dist != '0) && !mem_dist[TIME_W-1]) ?
                 mem_dist[DELAY_W-1:0] : '0;
  end

  // Plan admission and the next plan edge.
  always_comb begin
    free_slots = CAP_C - count_r;
    plan_need  = (req_r.illum_mask != '0) ? NEED_LIT : NEED_UNLIT;
    next_kind  = lit_r ? (cur_r.kind + KIND_W'(1)) : KIND_RELEASE;
    case (next_kind)
      KIND_ASSERT:    next_time = req_r.assert_time;
      KIND_ILLUM_ON:  next_time = req_r.illum_on_time;
      KIND_ILLUM_OFF: next_time = req_r.illum_off_time;
      default:        next_time = req_r.release_time;
    endcase
    sh_next = (CW + 1)'(idx_r) + (CW + 1)'(1);
  end

  // Sequencer: next state, memory accesses and result beat.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    cur_dist_nxt  = cur_dist_r;
    last_nxt      = last_r;
    lit_nxt       = lit_r;
    pop_nxt       = pop_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_ch.ready   = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = cur_r;
    rd_addr       = '0;
    edge_done     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          req_nxt   = in_ch.data;
          pop_nxt   = '0;
          acc_nxt   = 1'b0;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        cur_nxt.camera = req_r.camera_num;
        cur_nxt.mask   = req_r.illum_mask;
        state_nxt      = ST_FIN_RD;
        case (req_r.req_type)
          REQ_PUSH: begin
            if (count_r < CAP_C) begin
              cur_nxt.due_time = req_r.edge_time;
              cur_nxt.kind     = req_r.edge_kind;
              cur_dist_nxt     = req_r.edge_time - req_r.now_us;
              last_nxt         = 1'b1;
              lit_nxt          = 1'b0;
              state_nxt        = ST_INS_START;
            end
          end
          REQ_PLAN: begin
            if (free_slots >= plan_need) begin
              cur_nxt.due_time = req_r.assert_time;
              cur_nxt.kind     = KIND_ASSERT;
              cur_dist_nxt     = req_r.assert_time - req_r.now_us;
              last_nxt         = 1'b0;
              lit_nxt          = (req_r.illum_mask != '0);
              state_nxt        = ST_INS_START;
            end
          end
          REQ_POP: begin
            if (count_r != '0) begin
              state_nxt = ST_POP_RD;
            end
          end
          default: begin
            state_nxt = ST_FIN_RD;
          end
        endcase
      end

      // Open a hole at the tail and read the entry just above it.
      ST_INS_START: begin
        idx_nxt = AW'(count_r);
        if (count_r == '0) begin
          state_nxt = ST_INS_WR;
        end else begin
          rd_addr   = AW'(count_r - CW'(1));
          state_nxt = ST_INS_CMP;
        end
      end

      // Move the read entry down into the hole while the new edge runs first.
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (runs_first) begin
          wr_data = rd_data;
          idx_nxt = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = ST_INS_WR;
          end else begin
            rd_addr = idx_r - AW'(2);
          end
        end else begin
          edge_done = 1'b1;
        end
      end

      ST_INS_WR: begin
        wr_en     = 1'b1;
        edge_done = 1'b1;
      end

      ST_POP_RD: begin
        state_nxt = ST_POP_CHK;
      end

      // Head is due: take it and start closing the gap.
      ST_POP_CHK: begin
        state_nxt = ST_FIN_RD;
        if (head_due) begin
          pop_nxt   = rd_data;
          acc_nxt   = 1'b1;
          count_nxt = count_r - CW'(1);
          idx_nxt   = '0;
          if (count_r > CW'(1)) begin
            rd_addr   = AW'(1);
            state_nxt = ST_POP_SH;
          end
        end
      end

      ST_POP_SH: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        idx_nxt = idx_r + AW'(1);
        if (sh_next < (CW + 1)'(count_r)) begin
          rd_addr = idx_r + AW'(2);
        end else begin
          state_nxt = ST_FIN_RD;
        end
      end

      ST_FIN_RD: begin
        state_nxt = ST_FIN_WAIT;
      end

      // Head entry is on the read port; hold it until any earlier result is taken.
      ST_FIN_WAIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.accepted   = acc_r;
          out_nxt.out_time   = pop_r.due_time;
          out_nxt.out_kind   = pop_r.kind;
          out_nxt.out_camera = pop_r.camera;
          out_nxt.out_mask   = pop_r.mask;
          out_nxt.has_next   = (count_r != '0);
          out_nxt.head_wait  = delay;
          out_nxt.fill_count = FILL_W'(count_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // An edge has landed: count it and load the next plan edge, if any.
    if (edge_done) begin
      count_nxt = count_r + CW'(1);
      if (last_r) begin
        acc_nxt   = 1'b1;
        state_nxt = ST_FIN_RD;
      end else begin
        cur_nxt.kind     = next_kind;
        cur_nxt.due_time = next_time;
        cur_dist_nxt     = next_time - req_r.now_us;
        last_nxt         = (next_kind == KIND_RELEASE);
        state_nxt        = ST_INS_START;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("edge count above capacity");

  // An insert only starts while a free slot remains.
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_START) |-> (count_r < CAP_C))
    else $error("insert started into a full store");

  // A new result only appears from the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN_WAIT))
    else $error("result raised outside the finishing state");

  // An accepted beat always goes on to request decode.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_DISPATCH))
    else $error("accepted beat not decoded");

  // The fill count holds while the gap after a pop is closed.
  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_SH) |-> (count_nxt == count_r))
    else $error("fill count changed during pop shift");
`endif

endmodule

// File: src/timed_edge_priority_queue.sv
// ----------------------------------------------------------------------------
// Timed edge priority queue
// Keeps timed camera and illumination edges sorted by wrap-aware distance
// from the current time; serves single pushes, exposure plan pushes and pops
// of the due head edge.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    in_item_t  (one request per beat)
//  out_ch   out  valid / ready    out_item_t (one result per request beat)
//
//  An inserted edge moves past the stored edges one entry per cycle, and a
//  due pop closes the gap the same way, through the single store write port.
//  Reset is synchronous and active low; it empties the store at once.
//  A new request is taken while the previous result waits on out_ch; the
//  block stalls before its own result if that one has not been taken.
// ----------------------------------------------------------------------------
module timed_edge_priority_queue
  import tepq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tepq_in_if.sink    in_ch,
  tepq_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  edge_t         wr_data;
  logic [AW-1:0] rd_addr;
  edge_t         rd_data;

  // Edge memory.
  tepq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Insert / pop sequencer.
  tepq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: sim/timed_edge_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed edge priority queue: testbench
// Drives request beats into the queue and checks every result beat against
// a cycle-free model of the sorted edge store. A directed part covers tie
// breaks, wrap-aware ordering, due and early pops, plans and a full store.
// Random phases then replay realistic exposure traffic with some noise,
// under different idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module timed_edge_priority_queue_tb;
  import tepq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam logic [TIME_W-1:0] SIGN_BIAS = 32'h8000_0000;
  localparam int STUCK_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4 * (QUEUE_DEPTH + 2) + 40;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 450;

  logic clk;
  logic rst_n;

  tepq_in_if  in_ch ();
  tepq_out_if out_ch ();

  timed_edge_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Model of the edge store and the results still owed by the block.
  edge_t       model_edges [QUEUE_DEPTH];
  int          model_fill;
  out_item_t   pending_results [$];

  // Traffic knobs and bookkeeping.
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_requests;
  int          hold_served;
  logic [31:0] tb_clock;
  int          err_count;
  int          n_sent;
  int          n_results;
  int          n_due_pops;
  int          n_refused;
  int          n_full;
  int          stuck_cycles = 0;

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Distance from now, biased so that unsigned order means earlier.
  function automatic logic [31:0] biased_distance(logic [31:0] t, logic [31:0] now);
    return (t - now) ^ SIGN_BIAS;
  endfunction

  function automatic bit goes_first(edge_t a, edge_t b, logic [31:0] now);
    logic [31:0] da;
    logic [31:0] db;
    da = biased_distance(a.due_time, now);
    db = biased_distance(b.due_time, now);
    if (da != db) return da < db;
    return a.kind < b.kind;
  endfunction

  // Sorted insert; a new edge lands after any edge that compares equal.
  function automatic void insert_edge(edge_t e, logic [31:0] now);
    int i;
    i = model_fill;
    if (i >= QUEUE_DEPTH) return;
    while (i > 0 && goes_first(e, model_edges[i-1], now)) begin
      model_edges[i] = model_edges[i-1];
      i--;
    end
    model_edges[i] = e;
    model_fill++;
  endfunction

  // Applies one request to the model and returns the result beat it causes.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t   res;
    edge_t       e;
    int          need;
    int          i;
    logic [31:0] d;
    res = '0;
    e.due_time = '0;
    e.kind = KIND_ASSERT;
    e.camera = it.camera_num;
    e.mask = it.illum_mask;
    case (it.req_type)
      REQ_PUSH: begin
        if (model_fill < QUEUE_DEPTH) begin
          e.due_time = it.edge_time;
          e.kind = it.edge_kind;
          insert_edge(e, it.now_us);
          res.accepted = 1'b1;
        end
      end
      REQ_PLAN: begin
        need = (it.illum_mask != 0) ? PLAN_LIT_EDGES : PLAN_UNLIT_EDGES;
        if (QUEUE_DEPTH - model_fill >= need) begin
          e.kind = KIND_ASSERT;
          e.due_time = it.assert_time;
          insert_edge(e, it.now_us);
          if (it.illum_mask != 0) begin
            e.kind = KIND_ILLUM_ON;
            e.due_time = it.illum_on_time;
            insert_edge(e, it.now_us);
            e.kind = KIND_ILLUM_OFF;
            e.due_time = it.illum_off_time;
            insert_edge(e, it.now_us);
          end
          e.kind = KIND_RELEASE;
          e.due_time = it.release_time;
          insert_edge(e, it.now_us);
          res.accepted = 1'b1;
        end
      end
      REQ_POP: begin
        if (model_fill > 0 &&
            biased_distance(model_edges[0].due_time, it.now_us) <= SIGN_BIAS) begin
          res.accepted = 1'b1;
          res.out_time = model_edges[0].due_time;
          res.out_kind = model_edges[0].kind;
          res.out_camera = model_edges[0].camera;
          res.out_mask = model_edges[0].mask;
          for (i = 0; i < model_fill - 1; i++) model_edges[i] = model_edges[i+1];
          model_fill--;
        end
      end
      default: ;
    endcase
    // Status fields: fill and time left until the head edge.
    res.has_next = (model_fill > 0);
    if (model_fill > 0) begin
      d = model_edges[0].due_time - it.now_us;
      if (d != 0 && !d[31]) res.head_wait = d[DELAY_W-1:0];
    end
    res.fill_count = model_fill[FILL_W-1:0];
    return res;
  endfunction

  // A request with every field random, reserved code included.
  function automatic in_item_t noise_item();
    in_item_t it;
    it.req_type = REQ_W'($urandom_range(0, 3));
    it.now_us = $urandom;
    it.edge_time = $urandom;
    it.edge_kind = KIND_W'($urandom_range(0, 3));
    it.camera_num = CAM_W'($urandom_range(0, 255));
    it.illum_mask = MASK_W'($urandom_range(0, 255));
    it.assert_time = $urandom;
    it.illum_on_time = $urandom;
    it.illum_off_time = $urandom;
    it.release_time = $urandom;
    return it;
  endfunction

  // Realistic traffic: time moves forward, edges land a little ahead of it,
  // and pops are forced as the store fills so that it keeps draining.
  function automatic in_item_t flow_item();
    in_item_t    it;
    int          pick;
    logic [31:0] t;
    it = noise_item();
    pick = $urandom_range(0, 99);
    tb_clock = tb_clock + $urandom_range(0, 40);
    it.now_us = tb_clock;
    if (model_fill >= 13 + $urandom_range(0, 3) || pick < 40) begin
      it.req_type = REQ_POP;
      if (model_fill > 0 && $urandom_range(0, 2) == 0)
        it.now_us = model_edges[0].due_time + $urandom_range(0, 3);
    end else if (pick < 70) begin
      it.req_type = REQ_PUSH;
      it.edge_time = tb_clock + $urandom_range(0, 300);
    end else begin
      it.req_type = REQ_PLAN;
      t = tb_clock + $urandom_range(0, 200);
      it.assert_time = t;
      t = t + $urandom_range(0, 60);
      it.illum_on_time = t;
      t = t + $urandom_range(0, 60);
      it.illum_off_time = t;
      it.release_time = t + $urandom_range(0, 60);
      if ($urandom_range(0, 3) == 0) it.illum_mask = '0;
    end
    return it;
  endfunction

  // Offers one beat, with random idle cycles ahead of it, and records the
  // expected result once the block takes it.
  task automatic send_beat(input in_item_t it);
    out_item_t exp_r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_r = predict_result(it);
    pending_results.push_back(exp_r);
    n_sent++;
    if (!exp_r.accepted) n_refused++;
    else if (it.req_type == REQ_POP) n_due_pops++;
    if (model_fill == QUEUE_DEPTH) n_full++;
  endtask

  task automatic push_edge(input logic [31:0] now, input logic [31:0] t,
                           input logic [KIND_W-1:0] kind, input logic [7:0] cam,
                           input logic [7:0] mask);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_PUSH;
    it.now_us = now;
    it.edge_time = t;
    it.edge_kind = kind;
    it.camera_num = cam;
    it.illum_mask = mask;
    send_beat(it);
  endtask

  task automatic send_plan(input logic [31:0] now, input logic [7:0] cam,
                           input logic [7:0] mask, input logic [31:0] t_assert,
                           input logic [31:0] t_on, input logic [31:0] t_off,
                           input logic [31:0] t_release);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_PLAN;
    it.now_us = now;
    it.camera_num = cam;
    it.illum_mask = mask;
    it.assert_time = t_assert;
    it.illum_on_time = t_on;
    it.illum_off_time = t_off;
    it.release_time = t_release;
    send_beat(it);
  endtask

  task automatic pop_at(input logic [31:0] now);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_POP;
    it.now_us = now;
    send_beat(it);
  endtask

  // Empty pop, tie breaks, extreme distances, due and early pops, and the
  // reserved request code.
  task automatic test_ordering();
    logic [31:0] t0;
    in_item_t    it;
    t0 = tb_clock;
    pop_at(t0);
    push_edge(t0, t0 + 100, KIND_RELEASE, 8'd1, 8'h01);
    push_edge(t0, t0 + 100, KIND_ASSERT, 8'd2, 8'h02);
    push_edge(t0, t0 + 100, KIND_RELEASE, 8'd3, 8'h04);
    push_edge(t0, t0 + 32'h7FFF_FFFF, KIND_ILLUM_ON, 8'd4, 8'h08);
    push_edge(t0, t0 + SIGN_BIAS, KIND_ILLUM_OFF, 8'd5, 8'h10);
    pop_at(t0);
    pop_at(t0);
    pop_at(t0 + 100);
    it = noise_item();
    it.req_type = REQ_RESERVED;
    it.now_us = t0;
    send_beat(it);
  endtask

  // Unlit plan, then a lit plan whose times run backward with a tie.
  task automatic test_plans();
    logic [31:0] t0;
    t0 = tb_clock;
    send_plan(t0, 8'h80, 8'h00, t0 + 20, t0 + 30, t0 + 40, t0 + 50);
    send_plan(t0, 8'hFF, 8'hFF, t0 + 400, t0 + 50, t0 + 50, t0 + 10);
  endtask

  // Room checks at the edges: exactly two and four free slots, and refusals.
  task automatic test_full_store();
    logic [31:0] t0;
    t0 = tb_clock;
    send_plan(t0, 8'h00, 8'h5A, t0 + 60, t0 + 70, t0 + 80, t0 + 90);
    push_edge(32'hFFFF_FFFF, 32'h0000_0000, KIND_ASSERT, 8'h00, 8'h00);
    send_plan(t0, 8'h11, 8'h00, t0 + 5, t0, t0, t0 + 6);
    push_edge(t0, 32'hFFFF_FFFF, KIND_RELEASE, 8'hFF, 8'hFF);
    send_plan(t0, 8'h22, 8'h00, t0, t0, t0, t0);
    send_plan(t0, 8'h33, 8'hA5, t0, t0, t0, t0);
    repeat (4) pop_at(t0 + 1000);
    send_plan(t0, 8'h44, 8'h01, t0 + 1, t0 + 2, t0 + 3, t0 + 4);
  endtask

  // Mostly well-formed traffic with one request in ten pure noise.
  task automatic test_traffic(input int n, input int idle_pct, input int stall_pct,
                              input logic [31:0] start_clock);
    int k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    tb_clock = start_clock;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send_beat(noise_item());
      else send_beat(flow_item());
    end
  endtask

  // Output held off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (k = 0; k < 60; k++) send_beat(flow_item());
  endtask

  // Output ready: random stalls, or a counted hold-off when one is asked.
  initial begin : result_receiver
    int k;
    out_ch.ready = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_ch.ready <= 1'b0;
        for (k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: every result beat against the oldest expectation.
  always @(posedge clk) begin : result_checker
    out_item_t exp_r;
    out_item_t act_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act_r = out_ch.data;
      n_results++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: %p", $realtime, act_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (act_r.accepted !== exp_r.accepted || act_r.out_time !== exp_r.out_time ||
            act_r.out_kind !== exp_r.out_kind || act_r.out_camera !== exp_r.out_camera ||
            act_r.out_mask !== exp_r.out_mask || act_r.has_next !== exp_r.has_next ||
            act_r.head_wait !== exp_r.head_wait ||
            act_r.fill_count !== exp_r.fill_count) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("[%0t] result %0d mismatch", $realtime, n_results);
            $display("  expected: %p", exp_r);
            $display("  actual:   %p", act_r);
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d results outstanding", $realtime,
               STUCK_LIMIT, pending_results.size());
      $display("timed_edge_priority_queue_tb: done, errors");
      $finish;
    end
  end

  initial begin : main_sequence
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    model_fill = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    err_count = 0;
    n_sent = 0;
    n_results = 0;
    n_due_pops = 0;
    n_refused = 0;
    n_full = 0;
    tb_clock = 32'h0000_1000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ordering();
    test_plans();
    test_full_store();
    test_traffic(PHASE_ITEMS, 0, 0, 32'h0010_0000);
    test_traffic(PHASE_ITEMS, 75, 0, 32'hFFFF_8000);
    test_traffic(PHASE_ITEMS, 0, 75, 32'h7FFF_8000);
    test_backpressure();
    test_traffic(PHASE_ITEMS, 34, 34, $urandom);
    in_ch.valid <= 1'b0;

    // Let the last results come out, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d due pops, %0d refused or ignored.",
             n_sent, n_results, n_due_pops, n_refused);
    $display("Store was full after %0d requests; %0d mismatches.", n_full, err_count);
    if (err_count == 0)
      $display("timed_edge_priority_queue_tb: done, clean");
    else
      $display("timed_edge_priority_queue_tb: done, errors");
    $finish;
  end

endmodule

// File: timed_edge_priority_queue.f
src/tepq_pkg.sv
src/tepq_if.sv
src/tepq_store.sv
src/tepq_ctrl.sv
src/timed_edge_priority_queue.sv
sim/timed_edge_priority_queue_tb.sv
